/* rtl/ndp_pkg.sv */
// ----------------------------------------------------------------------------
// ndp_pkg
// Types, codes and constants shared by the neighbor message parser.
// ----------------------------------------------------------------------------
package ndp_pkg;

   localparam int unsigned DATA_W       = 8;
   localparam int unsigned OFFSET_W     = 16;
   localparam int unsigned OPT_END_W    = 17;
   localparam int unsigned LINK_W       = 48;
   localparam int unsigned WORD_W       = 64;
   localparam int unsigned ACTION_W     = 3;
   localparam int unsigned CSR_DATA_W   = 64;
   localparam int unsigned CSR_ADDR_W   = 6;
   localparam int unsigned CSR_INDEX_W  = 3;
   localparam int unsigned COUNT_W      = 2;

   localparam logic [DATA_W-1:0]   TYPE_NS      = 8'd135;
   localparam logic [DATA_W-1:0]   TYPE_NA      = 8'd136;
   localparam logic [DATA_W-1:0]   OPT_SRC_LL   = 8'd1;
   localparam logic [DATA_W-1:0]   OPT_TGT_LL   = 8'd2;
   localparam logic [DATA_W-1:0]   NS_OPT_LEN   = 8'd1;
   localparam logic [OFFSET_W-1:0] OPT_BASE     = 16'd24;
   localparam logic [OFFSET_W-1:0] OFFSET_MAX   = 16'hFFFF;
   localparam logic [OFFSET_W-1:0] TGT_HI_FIRST = 16'd8;
   localparam logic [OFFSET_W-1:0] TGT_HI_LAST  = 16'd15;
   localparam logic [OFFSET_W-1:0] TGT_LO_FIRST = 16'd16;
   localparam logic [OFFSET_W-1:0] TGT_LO_LAST  = 16'd23;
   localparam logic [OPT_END_W-1:0] UNIT_BYTES  = 17'd8;
   localparam logic [OPT_END_W-1:0] LL_FIRST    = 17'd2;
   localparam logic [OPT_END_W-1:0] LL_LAST     = 17'd7;

   localparam logic [ACTION_W-1:0] ACT_TOO_SHORT    = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_UNSUPPORTED  = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_NS_NOT_OURS  = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_NS_DAD       = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_NS_LEARN     = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_NS_NO_LINK   = 3'd5;
   localparam logic [ACTION_W-1:0] ACT_NA_LEARN     = 3'd6;
   localparam logic [ACTION_W-1:0] ACT_NA_NO_LINK   = 3'd7;

   localparam logic [CSR_INDEX_W-1:0] REG_ADDR0_HIGH = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ADDR0_LOW  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ADDR1_HIGH = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_ADDR1_LOW  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_ADDR_COUNT = 3'd4;

   typedef struct packed {
      logic [DATA_W-1:0] data;
      logic              last;
      logic              src_unspecified;
   } req_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [WORD_W-1:0]   target_high;
      logic [WORD_W-1:0]   target_low;
      logic [LINK_W-1:0]   link_addr;
      logic                link_addr_valid;
   } rsp_type;

   typedef struct packed {
      logic [WORD_W-1:0]  addr0_high;
      logic [WORD_W-1:0]  addr0_low;
      logic [WORD_W-1:0]  addr1_high;
      logic [WORD_W-1:0]  addr1_low;
      logic [COUNT_W-1:0] addr_count;
   } own_cfg_type;

endpackage

/* rtl/ndp_csr.sv */
// ----------------------------------------------------------------------------
// ndp_csr
// Register file for the own addresses and their count.
// ----------------------------------------------------------------------------
module ndp_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [ndp_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [ndp_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [ndp_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready,
   output ndp_pkg::own_cfg_type                cfg
);

   ndp_pkg::own_cfg_type cfg_ff, cfg_in;
   logic [ndp_pkg::CSR_INDEX_W-1:0] index;
   logic wr_en;

   assign index  = paddr[ndp_pkg::CSR_ADDR_W-1:ndp_pkg::CSR_ADDR_W-ndp_pkg::CSR_INDEX_W];
   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            ndp_pkg::REG_ADDR0_HIGH: cfg_in.addr0_high = pwdata;
            ndp_pkg::REG_ADDR0_LOW:  cfg_in.addr0_low  = pwdata;
            ndp_pkg::REG_ADDR1_HIGH: cfg_in.addr1_high = pwdata;
            ndp_pkg::REG_ADDR1_LOW:  cfg_in.addr1_low  = pwdata;
            ndp_pkg::REG_ADDR_COUNT: cfg_in.addr_count = pwdata[ndp_pkg::COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         ndp_pkg::REG_ADDR0_HIGH: prdata = cfg_ff.addr0_high;
         ndp_pkg::REG_ADDR0_LOW:  prdata = cfg_ff.addr0_low;
         ndp_pkg::REG_ADDR1_HIGH: prdata = cfg_ff.addr1_high;
         ndp_pkg::REG_ADDR1_LOW:  prdata = cfg_ff.addr1_low;
         ndp_pkg::REG_ADDR_COUNT:
            prdata = {{(ndp_pkg::CSR_DATA_W-ndp_pkg::COUNT_W){1'b0}}, cfg_ff.addr_count};
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* rtl/ndp_parse_core.sv */
// ----------------------------------------------------------------------------
// ndp_parse_core
// Per-message state: offset, type, target capture and option walk.
// ----------------------------------------------------------------------------
module ndp_parse_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  ndp_pkg::req_type     req,
   input  ndp_pkg::own_cfg_type cfg,
   output ndp_pkg::rsp_type     rsp
);

   localparam int unsigned OW = ndp_pkg::OFFSET_W;
   localparam int unsigned EW = ndp_pkg::OPT_END_W;
   localparam int unsigned DW = ndp_pkg::DATA_W;
   localparam int unsigned LW = ndp_pkg::LINK_W;
   localparam int unsigned WW = ndp_pkg::WORD_W;

   logic [OW-1:0] offset_ff, offset_in;
   logic [DW-1:0] mtype_ff, mtype_in;
   logic [WW-1:0] thigh_ff, thigh_in;
   logic [WW-1:0] tlow_ff, tlow_in;
   logic [EW-1:0] opt_end_ff, opt_end_in;
   logic [OW-1:0] opt_start_ff, opt_start_in;
   logic [DW-1:0] opt_kind_ff, opt_kind_in;
   logic          qual_ff, qual_in;
   logic          stopped_ff, stopped_in;
   logic [LW-1:0] pend_ff, pend_in;
   logic [LW-1:0] comm_ff, comm_in;
   logic          found_ff, found_in;

   logic [OW-1:0] o;
   logic [DW-1:0] b;
   logic [EW-1:0] o_ext, start_ext, diff;
   logic          is_ns, nd, walk_en, open_opt, skip_end, is_own, too_short;

   assign o         = offset_ff;
   assign b         = req.data;
   assign o_ext     = {1'b0, o};
   assign start_ext = {1'b0, opt_start_ff};
   assign diff      = o_ext - start_ext;
   assign open_opt  = (opt_end_ff == start_ext);

   always_comb begin
      mtype_in     = mtype_ff;
      thigh_in     = thigh_ff;
      tlow_in      = tlow_ff;
      opt_end_in   = opt_end_ff;
      opt_start_in = opt_start_ff;
      opt_kind_in  = opt_kind_ff;
      qual_in      = qual_ff;
      stopped_in   = stopped_ff;
      pend_in      = pend_ff;
      comm_in      = comm_ff;
      found_in     = found_ff;
      skip_end     = 1'b0;

      if (o == '0) begin
         mtype_in = b;
      end else if (o >= ndp_pkg::TGT_HI_FIRST && o <= ndp_pkg::TGT_HI_LAST) begin
         thigh_in = {thigh_ff[WW-DW-1:0], b};
      end else if (o >= ndp_pkg::TGT_LO_FIRST && o <= ndp_pkg::TGT_LO_LAST) begin
         tlow_in = {tlow_ff[WW-DW-1:0], b};
      end

      is_ns   = (mtype_in == ndp_pkg::TYPE_NS);
      nd      = is_ns || (mtype_in == ndp_pkg::TYPE_NA);
      walk_en = nd && (o >= ndp_pkg::OPT_BASE) && (o != ndp_pkg::OFFSET_MAX) && !stopped_ff;

      if (walk_en) begin
         if (o_ext == opt_end_ff) begin
            opt_start_in = o;
            opt_kind_in  = b;
            qual_in      = 1'b0;
            pend_in      = '0;
         end else if (open_opt && o_ext == start_ext + 17'd1) begin
            if (b == '0) begin
               stopped_in = 1'b1;
               skip_end   = 1'b1;
            end else if (is_ns) begin
               qual_in    = (opt_kind_ff == ndp_pkg::OPT_SRC_LL) && (b == ndp_pkg::NS_OPT_LEN);
               opt_end_in = start_ext + ndp_pkg::UNIT_BYTES;
            end else begin
               qual_in    = (opt_kind_ff == ndp_pkg::OPT_TGT_LL);
               opt_end_in = start_ext + {{(EW-DW-3){1'b0}}, b, 3'b000};
            end
         end else if (!open_opt && diff >= ndp_pkg::LL_FIRST && diff <= ndp_pkg::LL_LAST) begin
            pend_in = {pend_ff[LW-DW-1:0], b};
         end
         if (!skip_end && opt_end_in != {1'b0, opt_start_in} && o_ext + 17'd1 == opt_end_in) begin
            if (qual_in) begin
               comm_in  = pend_in;
               found_in = 1'b1;
            end
            if (is_ns) begin
               stopped_in = 1'b1;
            end
         end
      end

      offset_in = (o == ndp_pkg::OFFSET_MAX) ? o : o + 16'd1;
   end

   always_comb begin
      case (cfg.addr_count)
         2'd0:    is_own = 1'b0;
         2'd1:    is_own = (thigh_in == cfg.addr0_high) && (tlow_in == cfg.addr0_low);
         default: is_own = ((thigh_in == cfg.addr0_high) && (tlow_in == cfg.addr0_low)) ||
                           ((thigh_in == cfg.addr1_high) && (tlow_in == cfg.addr1_low));
      endcase
   end

   assign too_short = (o < ndp_pkg::TGT_LO_LAST);

   always_comb begin
      rsp = '0;
      if (!nd) begin
         rsp.action = ndp_pkg::ACT_UNSUPPORTED;
      end else if (too_short) begin
         rsp.action = ndp_pkg::ACT_TOO_SHORT;
      end else begin
         if (is_ns) begin
            if (!is_own) begin
               rsp.action = ndp_pkg::ACT_NS_NOT_OURS;
            end else if (req.src_unspecified) begin
               rsp.action = ndp_pkg::ACT_NS_DAD;
            end else if (found_in) begin
               rsp.action = ndp_pkg::ACT_NS_LEARN;
            end else begin
               rsp.action = ndp_pkg::ACT_NS_NO_LINK;
            end
         end else begin
            rsp.action = found_in ? ndp_pkg::ACT_NA_LEARN : ndp_pkg::ACT_NA_NO_LINK;
         end
         rsp.target_high     = thigh_in;
         rsp.target_low      = tlow_in;
         rsp.link_addr       = found_in ? comm_in : '0;
         rsp.link_addr_valid = found_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step && req.last)) begin
         offset_ff    <= '0;
         mtype_ff     <= '0;
         thigh_ff     <= '0;
         tlow_ff      <= '0;
         opt_end_ff   <= {1'b0, ndp_pkg::OPT_BASE};
         opt_start_ff <= ndp_pkg::OPT_BASE;
         opt_kind_ff  <= '0;
         qual_ff      <= 1'b0;
         stopped_ff   <= 1'b0;
         pend_ff      <= '0;
         comm_ff      <= '0;
         found_ff     <= 1'b0;
      end else if (step) begin
         offset_ff    <= offset_in;
         mtype_ff     <= mtype_in;
         thigh_ff     <= thigh_in;
         tlow_ff      <= tlow_in;
         opt_end_ff   <= opt_end_in;
         opt_start_ff <= opt_start_in;
         opt_kind_ff  <= opt_kind_in;
         qual_ff      <= qual_in;
         stopped_ff   <= stopped_in;
         pend_ff      <= pend_in;
         comm_ff      <= comm_in;
         found_ff     <= found_in;
      end
   end

endmodule

/* rtl/ndp_neighbor_message_parser.sv */
// ----------------------------------------------------------------------------
// ndp_neighbor_message_parser
// Neighbor solicitation/advertisement receive parser, one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  req       in         req_valid / req_stall   ndp_pkg::req_type (byte, last, src flag)
//  rsp       out        rsp_valid / rsp_stall   ndp_pkg::rsp_type (action, target, link)
//  csr       in/out     psel/penable/pwrite     64-bit registers at 8*index
//
//  Takes one byte per cycle unless req_stall is high; the parse state advances
//  as a byte leaves the input register. The result of a message is registered
//  as its last byte leaves the input register. A stalled result holds the next
//  message's last byte in the input register; other bytes keep flowing. Reset
//  is synchronous and clears all parse state.
// ----------------------------------------------------------------------------
module ndp_neighbor_message_parser (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  ndp_pkg::req_type                req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output ndp_pkg::rsp_type                rsp_payload,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [ndp_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [ndp_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [ndp_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready
);

   ndp_pkg::own_cfg_type cfg;
   ndp_pkg::req_type     in_ff;
   ndp_pkg::rsp_type     out_ff, result;
   logic                 in_valid_ff, in_valid_in;
   logic                 out_valid_ff, out_valid_in;
   logic                 consume, accept;

   ndp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   ndp_parse_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (consume),
      .req   (in_ff),
      .cfg   (cfg),
      .rsp   (result)
   );

   assign consume   = in_valid_ff && (!in_ff.last || !out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !consume;
   assign accept    = req_valid && !req_stall;

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (consume) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (consume && in_ff.last) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_ff <= req_payload;
      end
      if (consume && in_ff.last) begin
         out_ff <= result;
      end
   end

endmodule
